/* rtl/core/newton_divided_difference_interp_assert.svh */
// assertion macros for the interpolator
`ifndef NEWTON_DIVIDED_DIFFERENCE_INTERP_ASSERT_SVH
`define NEWTON_DIVIDED_DIFFERENCE_INTERP_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define NDDI_ASSERT_IMP(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("check failed");
// next-cycle implication checked outside reset
`define NDDI_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("check failed");
`endif

/* rtl/core/nddi_pkg.sv */
package nddi_pkg;
   localparam int MaxPointsDefault = 8;
   localparam int FracBitsDefault  = 16;
   localparam int DataWidth        = 32;

   localparam logic [1:0] OP_ADD   = 2'd0;
   localparam logic [1:0] OP_EVAL  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_REP  = 2'd2;
   localparam logic [1:0] ST_SAT  = 2'd3;

   // clamp a 66-bit value to 32-bit signed
   function automatic logic [32:0] clamp66(input logic signed [65:0] v);
      logic [32:0] r;
      if (v > 66'sd2147483647) r = {1'b1, 32'h7fffffff};
      else if (v < -66'sd2147483648) r = {1'b1, 32'h80000000};
      else r = {1'b0, v[31:0]};
      return r;
   endfunction
endpackage

/* rtl/core/newton_divided_difference_interp.sv */
// Newton divided-difference interpolator in signed fixed point with FRAC_BITS
// fraction bits, holding up to MAX_POINTS nodes. Each req transfer carries an
// operation (add point, evaluate, clear) and gives exactly one rsp transfer
// with the polynomial value, the degree after the step (-1 when empty) and a
// status code. Items are handled one at a time: req_tready is high only when
// the block is idle and no result is waiting. The points sit in a ring of
// cells that rotates one place per step, so one lap presents them at a fixed
// tap from the highest index down. Clear, an unused code, an add on a full
// store and an evaluate with no points are answered from the idle state;
// an add runs one lap through the bit-serial divider at each stored point
// before a repeated node; an evaluate runs one lap with a multiply and an
// accumulate step per point below the top. A result waits in an output
// register until taken.
module newton_divided_difference_interp import nddi_pkg::*; #(
   parameter int MAX_POINTS = MaxPointsDefault,
   parameter int FRAC_BITS  = FracBitsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata, // operation[1:0], abscissa[33:2], ordinate[65:34], zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata  // poly_value[31:0], degree[35:32], status[37:36], zero
);
`include "newton_divided_difference_interp_assert.svh"
   localparam int PW  = $clog2(MAX_POINTS + 1);
   localparam int IW  = $clog2(MAX_POINTS);
   localparam int W   = DataWidth;
   localparam int TAP = MAX_POINTS - 1;

   localparam logic [2:0] S_IDLE = 3'd0, S_STEP = 3'd1, S_DIV = 3'd2,
      S_MUL = 3'd3, S_ACC = 3'd4, S_DONE = 3'd5;

   logic [2:0] st_ff, st_in;
   logic [PW-1:0] cnt_ff, cnt_in;   // stored points
   logic [IW-1:0] lap_ff, lap_in;   // index sitting at the tap
   logic [1:0] op_ff, op_in;
   logic [W-1:0] x_ff, x_in;
   logic [W-1:0] col_ff, col_in;    // most recent new entry
   logic signed [W-1:0] acc_ff, acc_in;
   logic signed [W-1:0] d_ff, d_in;
   logic signed [2*W-1:0] p_ff, p_in;
   logic sat_ff, sat_in, rep_ff, rep_in;
   logic [W-1:0] newd_ff [MAX_POINTS];
   logic ov_ff, ov_in;
   logic [39:0] out_ff, out_in;
   logic out_load;
   logic [1:0] out_st;
   logic [W-1:0] out_val;
   logic [3:0] out_deg;
   logic newd_we;
   logic [IW-1:0] newd_idx;
   logic [W-1:0] newd_val;
   logic advance;

   // ring of cells; each cell takes the one below, cell 0 takes the last
   logic [W-1:0] nq [MAX_POINTS];
   logic [W-1:0] dq [MAX_POINTS];
   logic [W-1:0] cq [MAX_POINTS];
   logic shift;
   logic [MAX_POINTS-1:0] ld_d, ld_n;

   genvar g;
   generate
      for (g = 0; g < MAX_POINTS; g++) begin : g_cell
         nddi_cell u_cell (
            .clock(clock), .shift(shift),
            .node_prev(nq[(g+MAX_POINTS-1)%MAX_POINTS]),
            .diff_prev(dq[(g+MAX_POINTS-1)%MAX_POINTS]),
            .coef_prev(cq[(g+MAX_POINTS-1)%MAX_POINTS]),
            .load_diff(ld_d[g]), .diff_new(newd_ff[g]),
            .load_new(ld_n[g]), .node_new(x_ff), .coef_new(col_ff),
            .node_q(nq[g]), .diff_q(dq[g]), .coef_q(cq[g]));
      end
   endgenerate

   // divider
   logic dv_start, dv_done, dv_ovf;
   logic signed [W:0] dv_num, dv_den;
   logic signed [W-1:0] dv_q;
   nddi_divider #(.FracBits(FRAC_BITS)) u_div (
      .clock(clock), .reset(reset), .start(dv_start), .numer(dv_num),
      .denom(dv_den), .done(dv_done), .quot(dv_q), .ovf(dv_ovf));

   // tap arithmetic for evaluate
   logic signed [65:0] diff_w, prod_w, sum_w;
   logic [32:0] d_cl, p_cl, s_cl;
   logic tap_live, tap_top, tap_mid;

   always_comb begin
      dv_num = $signed({col_ff[W-1], col_ff}) - $signed({dq[TAP][W-1], dq[TAP]});
      dv_den = $signed({x_ff[W-1], x_ff}) - $signed({nq[TAP][W-1], nq[TAP]});
      diff_w = $signed({{(66-W){x_ff[W-1]}}, x_ff}) -
         $signed({{(66-W){nq[TAP][W-1]}}, nq[TAP]});
      d_cl = clamp66(diff_w);
      prod_w = $signed({{2{p_ff[2*W-1]}}, p_ff}) >>> FRAC_BITS;
      p_cl = clamp66(prod_w);
      sum_w = $signed({{(66-W){p_cl[W-1]}}, p_cl[W-1:0]}) +
         $signed({{(66-W){cq[TAP][W-1]}}, cq[TAP]});
      s_cl = clamp66(sum_w);
      tap_live = PW'(lap_ff) < cnt_ff;
      tap_top = PW'(lap_ff) == cnt_ff - PW'(1);
      tap_mid = PW'(lap_ff) + PW'(1) < cnt_ff;
   end

   // control
   always_comb begin
      st_in = st_ff; cnt_in = cnt_ff; lap_in = lap_ff; op_in = op_ff;
      x_in = x_ff; col_in = col_ff; acc_in = acc_ff; d_in = d_ff; p_in = p_ff;
      sat_in = sat_ff; rep_in = rep_ff;
      shift = 1'b0; dv_start = 1'b0; ld_d = '0; ld_n = '0;
      newd_we = 1'b0; newd_idx = lap_ff; newd_val = dv_q;
      out_load = 1'b0; out_st = ST_OK; out_val = '0;
      advance = 1'b0;
      unique case (st_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               op_in = req_tdata[1:0];
               x_in = req_tdata[33:2];
               col_in = req_tdata[65:34];
               sat_in = 1'b0; rep_in = 1'b0;
               lap_in = IW'(MAX_POINTS - 1);
               unique case (req_tdata[1:0])
                  OP_ADD: begin
                     if (cnt_ff < PW'(MAX_POINTS)) begin
                        newd_we = 1'b1;
                        newd_idx = cnt_ff[IW-1:0];
                        newd_val = req_tdata[65:34];
                        st_in = S_STEP;
                     end else begin
                        out_load = 1'b1;
                        out_st = ST_FULL;
                     end
                  end
                  OP_EVAL: begin
                     if (cnt_ff != '0) st_in = S_STEP;
                     else out_load = 1'b1;
                  end
                  OP_CLEAR: begin
                     cnt_in = '0;
                     out_load = 1'b1;
                  end
                  default: out_load = 1'b1;
               endcase
            end
         end
         // one lap position: check node and divide, or start a horner step
         S_STEP: begin
            if (op_ff == OP_ADD) begin
               if (tap_live && !rep_ff) begin
                  if (nq[TAP] == x_ff) begin
                     rep_in = 1'b1;
                     advance = 1'b1;
                  end else begin
                     dv_start = 1'b1;
                     st_in = S_DIV;
                  end
               end else begin
                  advance = 1'b1;
               end
            end else begin
               if (tap_top) begin
                  acc_in = cq[TAP];
                  advance = 1'b1;
               end else if (tap_mid) begin
                  d_in = d_cl[W-1:0];
                  if (d_cl[W]) sat_in = 1'b1;
                  st_in = S_MUL;
               end else begin
                  advance = 1'b1;
               end
            end
         end
         S_DIV: begin
            if (dv_done) begin
               col_in = dv_q;
               if (dv_ovf) sat_in = 1'b1;
               newd_we = 1'b1;
               advance = 1'b1;
            end
         end
         S_MUL: begin
            p_in = acc_ff * d_ff;
            st_in = S_ACC;
         end
         S_ACC: begin
            acc_in = s_cl[W-1:0];
            if (p_cl[W] || s_cl[W]) sat_in = 1'b1;
            advance = 1'b1;
         end
         // ring is home: store the new column or report
         S_DONE: begin
            out_load = 1'b1;
            st_in = S_IDLE;
            if (op_ff == OP_ADD) begin
               if (rep_ff) begin
                  out_st = ST_REP;
               end else if (sat_ff) begin
                  out_st = ST_SAT;
               end else begin
                  for (int i = 0; i < MAX_POINTS; i++)
                     if (PW'(i) <= cnt_ff) ld_d[i] = 1'b1;
                  ld_n[cnt_ff[IW-1:0]] = 1'b1;
                  cnt_in = cnt_ff + PW'(1);
               end
            end else begin
               out_val = acc_ff;
               out_st = sat_ff ? ST_SAT : ST_OK;
            end
         end
         default: st_in = S_IDLE;
      endcase

      // rotate the ring one place and move to the next index
      if (advance) begin
         shift = 1'b1;
         if (lap_ff == '0) begin
            st_in = S_DONE;
         end else begin
            lap_in = lap_ff - IW'(1);
            st_in = S_STEP;
         end
      end

      out_deg = 4'(int'(cnt_in) + 15);
      out_in = {2'b00, out_st, out_deg, out_val};
      ov_in = out_load | (ov_ff & ~rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         cnt_ff <= '0;
         ov_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         cnt_ff <= cnt_in;
         ov_ff <= ov_in;
      end
      lap_ff <= lap_in; op_ff <= op_in; x_ff <= x_in; col_ff <= col_in;
      acc_ff <= acc_in; d_ff <= d_in; p_ff <= p_in;
      sat_ff <= sat_in; rep_ff <= rep_in;
      if (out_load) out_ff <= out_in;
      if (newd_we) newd_ff[newd_idx] <= newd_val;
   end

   assign req_tready = (st_ff == S_IDLE) && !ov_ff;
   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = out_ff;

   `NDDI_ASSERT_IMP(a_busy_not_ready, clock, reset, st_ff != S_IDLE, !req_tready)
   `NDDI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata))
   `NDDI_ASSERT_IMP(a_count_range, clock, reset, 1'b1, cnt_ff <= PW'(MAX_POINTS))
endmodule

/* rtl/core/nddi_divider.sv */
// restoring divider, one quotient bit per cycle, truncates toward zero
// done pulses once the last quotient bit is in, with quot and ovf valid
module nddi_divider import nddi_pkg::*; #(
   parameter int FracBits = FracBitsDefault
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic signed [DataWidth:0]   numer,
   input  logic signed [DataWidth:0]   denom,
   output logic                        done,
   output logic signed [DataWidth-1:0] quot,
   output logic                        ovf
);
   localparam int NW = DataWidth + 1 + FracBits;
   localparam int CW = $clog2(NW + 1);

   logic [NW-1:0] q_ff, q_in;
   logic [NW:0]   r_ff, r_in;
   logic [DataWidth:0] d_ff, d_in;
   logic neg_ff, neg_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [NW:0] shl;
   logic [NW:0] dext;
   logic [NW:0] sq;
   logic [DataWidth:0] nabs;

   // operand capture and one shift-subtract step per cycle
   always_comb begin
      nabs = numer[DataWidth] ? (DataWidth+1)'(0) - numer : numer;
      dext = {{(NW-DataWidth){1'b0}}, d_ff};
      shl = {r_ff[NW-1:0], q_ff[NW-1]};
      q_in = q_ff; r_in = r_ff; d_in = d_ff; neg_in = neg_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      if (start) begin
         q_in = {nabs, {FracBits{1'b0}}};
         r_in = '0;
         d_in = denom[DataWidth] ? (DataWidth+1)'(0) - denom : denom;
         neg_in = numer[DataWidth] ^ denom[DataWidth];
         cnt_in = CW'(NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (shl >= dext) begin
            r_in = shl - dext;
            q_in = {q_ff[NW-2:0], 1'b1};
         end else begin
            r_in = shl;
            q_in = {q_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in; neg_ff <= neg_in;
   end

   // sign and range of magnitude
   always_comb begin
      sq = neg_ff ? (NW+1)'(0) - {1'b0, q_ff} : {1'b0, q_ff};
      if (neg_ff) ovf = q_ff > NW'(33'h80000000);
      else ovf = q_ff > NW'(32'h7fffffff);
      quot = sq[DataWidth-1:0];
   end
   assign done = done_ff;
endmodule

/* rtl/core/nddi_cell.sv */
// one storage cell: node, divided difference, coefficient; shifts to neighbor
module nddi_cell import nddi_pkg::*; (
   input  logic                 clock,
   input  logic                 shift,
   input  logic [DataWidth-1:0] node_prev,
   input  logic [DataWidth-1:0] diff_prev,
   input  logic [DataWidth-1:0] coef_prev,
   input  logic                 load_diff,
   input  logic [DataWidth-1:0] diff_new,
   input  logic                 load_new,
   input  logic [DataWidth-1:0] node_new,
   input  logic [DataWidth-1:0] coef_new,
   output logic [DataWidth-1:0] node_q,
   output logic [DataWidth-1:0] diff_q,
   output logic [DataWidth-1:0] coef_q
);
   logic [DataWidth-1:0] node_ff, diff_ff, coef_ff;
   always_ff @(posedge clock) begin
      if (shift) begin
         node_ff <= node_prev;
         diff_ff <= diff_prev;
         coef_ff <= coef_prev;
      end else begin
         if (load_diff) diff_ff <= diff_new;
         if (load_new) begin
            node_ff <= node_new;
            coef_ff <= coef_new;
         end
      end
   end
   assign node_q = node_ff;
   assign diff_q = diff_ff;
   assign coef_q = coef_ff;
endmodule

/* dv/tb_newton_divided_difference_interp.sv */
`timescale 1ns / 1ps

module tb_newton_divided_difference_interp;
   import nddi_pkg::*;

   localparam int NPTS = MaxPointsDefault;
   localparam int FB   = FracBitsDefault;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic [31:0] ordinate;
      logic [31:0] abscissa;
      logic [1:0]  op;
   } interp_req_t;

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  degree;
      logic [31:0] poly_value;
   } interp_rsp_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;

   newton_divided_difference_interp dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always #5 clock = ~clock;

   // predictor state
   logic signed [31:0] node_q [NPTS];
   logic signed [31:0] diff_q [NPTS];
   logic signed [31:0] coef_q [NPTS];
   int unsigned        npts_q;

   interp_req_t pending_reqs [$];
   interp_rsp_t expected_rsps [$];
   int  mismatches = 0;
   int  idle_cycles = 0;
   int  tx_wait = 0;
   int  rx_wait = 0;

   function automatic longint sat32(input longint v, inout bit sat);
      if (v > 64'sd2147483647) begin
         sat = 1'b1;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         sat = 1'b1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   // floor shift of a 128-bit product
   function automatic longint floor_frac(input logic signed [127:0] p, inout bit sat);
      logic signed [127:0] s;
      s = p >>> FB;
      if (s > 128'sd2147483647) begin
         sat = 1'b1;
         return 64'sd2147483647;
      end
      if (s < -128'sd2147483648) begin
         sat = 1'b1;
         return -64'sd2147483648;
      end
      return longint'(s);
   endfunction

   function automatic logic [1:0] insert_node(input longint node, input longint value);
      logic signed [31:0] col [NPTS];
      bit     sat;
      longint num, den, q;
      sat = 1'b0;
      if (npts_q >= NPTS) return ST_FULL;
      for (int i = 0; i < npts_q; i++)
         if (longint'(node_q[i]) == node) return ST_REP;
      col[npts_q] = 32'(value);
      for (int i = npts_q; i > 0; i--) begin
         num = longint'(col[i]) - longint'(diff_q[i-1]);
         den = node - longint'(node_q[i-1]);
         q = (num * (64'sd1 <<< FB)) / den;
         col[i-1] = 32'(sat32(q, sat));
      end
      if (sat) return ST_SAT;
      for (int i = 0; i <= npts_q; i++) diff_q[i] = col[i];
      coef_q[npts_q] = col[0];
      node_q[npts_q] = 32'(node);
      npts_q++;
      return ST_OK;
   endfunction

   function automatic longint horner_eval(input longint x, output logic [1:0] st);
      bit     sat;
      int     n;
      longint acc, d, p;
      sat = 1'b0;
      st = ST_OK;
      if (npts_q == 0) return 0;
      n = npts_q - 1;
      acc = coef_q[n];
      for (int i = 1; i <= n; i++) begin
         d = sat32(x - longint'(node_q[n-i]), sat);
         p = floor_frac(128'(acc) * 128'(d), sat);
         acc = sat32(p + longint'(coef_q[n-i]), sat);
      end
      if (sat) st = ST_SAT;
      return acc;
   endfunction

   function automatic interp_rsp_t predict_rsp(input interp_req_t r);
      interp_rsp_t e;
      e = '0;
      case (r.op)
         OP_ADD: e.status = insert_node(longint'($signed(r.abscissa)),
                                        longint'($signed(r.ordinate)));
         OP_EVAL: e.poly_value = 32'(horner_eval(longint'($signed(r.abscissa)), e.status));
         OP_CLEAR: npts_q = 0;
         default: ;
      endcase
      e.degree = 4'(npts_q + 15);
      return e;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         expected_rsps.insert(expected_rsps.size(),
                              predict_rsp(interp_req_t'(req_tdata[65:0])));
         tx_wait = $urandom_range(0, 11);
         if (tx_wait == 0 && pending_reqs.size() > 0) begin
            req_tdata <= {6'b0, pending_reqs.pop_front()};
         end else begin
            req_tvalid <= 1'b0;
         end
      end else if (!req_tvalid) begin
         if (tx_wait > 0) tx_wait--;
         else if (pending_reqs.size() > 0) begin
            req_tdata <= {6'b0, pending_reqs.pop_front()};
            req_tvalid <= 1'b1;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      interp_rsp_t got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = interp_rsp_t'(rsp_tdata[37:0]);
            if (expected_rsps.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result %h", got);
            end else begin
               want = expected_rsps.pop_front();
               if (got.poly_value !== want.poly_value || got.degree !== want.degree ||
                   got.status !== want.status) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp val %h deg %h st %h, got val %h deg %h st %h",
                              want.poly_value, want.degree, want.status,
                              got.poly_value, got.degree, got.status);
               end
            end
            rx_wait = $urandom_range(0, 11);
            if (rx_wait > 0) rsp_tready <= 1'b0;
         end else if (rx_wait > 0) begin
            rx_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("newton_divided_difference_interp verification failed");
         $finish;
      end
   end

   task automatic queue_req(input logic [1:0] op, input logic [31:0] a, input logic [31:0] o);
      pending_reqs.insert(pending_reqs.size(), '{op: op, abscissa: a, ordinate: o});
   endtask

   function automatic logic [31:0] rand_node();
      case ($urandom_range(0, 3))
         0: return $urandom();
         1: return 32'($signed($urandom_range(0, 16)) - 8) <<< FB;
         default: return $urandom_range(0, 32'h3ffff) - 32'h20000;
      endcase
   endfunction

   initial begin
      int n;
      for (int i = 0; i < NPTS; i++) begin
         node_q[i] = '0; diff_q[i] = '0; coef_q[i] = '0;
      end
      npts_q = 0;
      // directed: empty eval, unused code, extremes, repeated node, full, clear
      queue_req(OP_EVAL, 32'h0001_0000, 32'h0);
      queue_req(2'd3, 32'hffff_ffff, 32'hffff_ffff);
      queue_req(OP_ADD, 32'h8000_0000, 32'h7fff_ffff);
      queue_req(OP_ADD, 32'h8000_0000, 32'h0);
      queue_req(OP_ADD, 32'h7fff_ffff, 32'h8000_0000);
      queue_req(OP_EVAL, 32'h0, 32'h0);
      queue_req(OP_EVAL, 32'h7fff_ffff, 32'hffff_ffff);
      queue_req(OP_ADD, 32'h0000_0001, 32'h7fff_ffff);
      queue_req(OP_CLEAR, 32'h0, 32'h0);
      for (int i = 0; i < 9; i++) queue_req(OP_ADD, 32'(i << FB), 32'((i * i) << FB));
      queue_req(OP_EVAL, 32'h0002_8000, 32'h0);
      queue_req(OP_EVAL, 32'h8000_0000, 32'h0);
      queue_req(OP_CLEAR, 32'hffff_ffff, 32'hffff_ffff);
      queue_req(OP_EVAL, 32'h0001_0000, 32'h0);
      // random: mostly fills with evaluations, some noise
      n = 0;
      while (n < 700) begin
         if ($urandom_range(0, 9) == 0) begin
            queue_req(2'($urandom_range(0, 3)), $urandom(), $urandom());
            n++;
         end else begin
            queue_req(OP_CLEAR, $urandom(), $urandom());
            n++;
            for (int k = $urandom_range(1, NPTS + 1); k > 0; k--) begin
               queue_req(OP_ADD, rand_node(),
                         $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 32'hfffff));
               n++;
            end
            for (int k = $urandom_range(1, 4); k > 0; k--) begin
               queue_req(OP_EVAL, rand_node(), $urandom());
               n++;
            end
         end
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      wait (pending_reqs.size() == 0 && !req_tvalid);
      wait (expected_rsps.size() == 0);
      repeat (200) @(posedge clock);
      if (mismatches == 0 && expected_rsps.size() == 0)
         $display("newton_divided_difference_interp verification clean");
      else
         $display("newton_divided_difference_interp verification failed");
      $finish;
   end

endmodule

/* newton_divided_difference_interp.f */
+incdir+rtl/core
rtl/core/nddi_pkg.sv
rtl/core/nddi_divider.sv
rtl/core/nddi_cell.sv
rtl/core/newton_divided_difference_interp.sv
dv/tb_newton_divided_difference_interp.sv
